[hw/rtl/crbm_pkg.sv]
package crbm_pkg;

    localparam int KIND_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int FILL_W      = 6;
    localparam int PAT_W       = 64;
    localparam int PLEN_W      = 4;
    localparam int PATTERN_MAX = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH    = 3'd0,
        K_POP     = 3'd1,
        K_PEEK    = 3'd2,
        K_CLEAR   = 3'd3,
        K_COMPARE = 3'd4,
        K_LIMITED = 3'd5,
        K_ENDS    = 3'd6,
        K_DUMP    = 3'd7
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 1'b0,
        CFG_PATTERN_LENGTH = 1'b1
    } cfg_reg_t;

    typedef logic signed [1:0] order_t;

    localparam order_t ORD_LESS    = 2'sb11;
    localparam order_t ORD_EQUAL   = 2'sb00;
    localparam order_t ORD_GREATER = 2'sb01;

    typedef struct packed {
        logic   latch_in;
        logic   do_push;
        logic   do_pop;
        logic   do_clear;
        logic   walk_head;
        logic   walk_tail;
        logic   walk_step;
        logic   rd_en;
        logic   set_refused;
        logic   take_byte;
        logic   set_order;
        order_t order_val;
        logic   set_sfx;
        logic   sfx_val;
        logic   emit;
    } cmd_t;

    typedef struct packed {
        kind_t  kind;
        logic   full;
        logic   empty;
        logic   out_free;
        logic   cmp_more;
        order_t cmp_end;
        logic   byte_lt;
        logic   byte_gt;
        logic   sfx_short;
        logic   sfx_done;
        logic   dump_none;
        logic   res_last;
    } status_t;

endpackage

[hw/rtl/crbm_dp.sv]
module crbm_dp #(
    parameter int DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  crbm_pkg::cmd_t                     cmd,
    output crbm_pkg::status_t                  status,
    input  logic [crbm_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [crbm_pkg::KIND_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [crbm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [crbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crbm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import crbm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int WW = ((AW > LEN_W) ? AW : LEN_W) + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [AW-1:0] DEPTH_MOD = AW'(DEPTH);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] mem_q_reg;

    logic [AW-1:0]     rd_idx_reg;
    logic [AW-1:0]     wr_idx_reg;
    logic [AW-1:0]     pos_reg;
    logic [LEN_W-1:0]  k_reg;
    logic [LEN_W-1:0]  cnt_reg;
    kind_t             kind_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [PAT_W-1:0]  pat_bytes_reg;
    logic [PLEN_W-1:0] pat_len_reg;

    logic [BYTE_W-1:0] res_byte_reg;
    logic              res_valid_reg;
    order_t            res_order_reg;
    logic              res_sfx_reg;
    logic              res_refused_reg;
    logic              res_last_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_byte_valid_reg;
    logic [FILL_W-1:0] out_fill_reg;
    order_t            out_order_reg;
    logic              out_sfx_reg;
    logic              out_refused_reg;
    logic              out_last_reg;

    logic [AW-1:0]     fill;
    logic [WW-1:0]     fill_x;
    logic [WW-1:0]     len_x;
    logic [WW-1:0]     k_x;
    logic [WW-1:0]     plen_x;
    logic [PLEN_W-1:0] plen;
    logic [PLEN_W-1:0] plen_cap;
    logic              plen_found;
    logic [WW-1:0]     n_wide;
    logic [LEN_W-1:0]  n_now;
    logic [AW-1:0]     n_slots;
    logic [AW-1:0]     tail_pos;
    logic [BYTE_W-1:0] pat_k;
    logic              out_free;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
        return (i == LAST_SLOT) ? '0 : AW'(i + 1'b1);
    endfunction

    // held characters, wrap-aware for any depth
    assign fill   = AW'(wr_idx_reg - rd_idx_reg + ((wr_idx_reg >= rd_idx_reg) ? '0 : DEPTH_MOD));
    assign fill_x = WW'(fill);
    assign len_x  = WW'(len_reg);
    assign k_x    = WW'(k_reg);
    assign plen_x = WW'(plen);

    // effective pattern length: clamp, then stop at first zero byte
    always_comb
    begin
        plen_cap   = (pat_len_reg > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX) : pat_len_reg;
        plen       = plen_cap;
        plen_found = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (!plen_found && (PLEN_W'(i) < plen_cap) && (pat_bytes_reg[8*i +: 8] == '0))
            begin
                plen       = PLEN_W'(i);
                plen_found = 1'b1;
            end
        end
    end

    assign pat_k = pat_bytes_reg[8*k_reg[2:0] +: 8];

    always_comb
    begin
        if (kind_reg == K_ENDS)
        begin
            n_wide = (len_x < plen_x) ? len_x : plen_x;
        end
        else
        begin
            n_wide = (len_x < fill_x) ? len_x : fill_x;
        end
    end

    assign n_now    = n_wide[LEN_W-1:0];
    assign n_slots  = AW'(n_now);
    assign tail_pos = AW'(wr_idx_reg - n_slots + ((wr_idx_reg >= n_slots) ? '0 : DEPTH_MOD));
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        status.kind      = kind_reg;
        status.full      = (fill == LAST_SLOT);
        status.empty     = (fill == '0);
        status.out_free  = out_free;
        status.cmp_more  = (k_x < fill_x) && (k_x < plen_x)
                           && !((kind_reg == K_LIMITED) && (k_x == len_x));
        if ((kind_reg == K_LIMITED) && (k_x == len_x))
        begin
            status.cmp_end = ORD_EQUAL;
        end
        else if ((k_x == fill_x) && (k_x == plen_x))
        begin
            status.cmp_end = ORD_EQUAL;
        end
        else if (k_x == plen_x)
        begin
            status.cmp_end = ORD_GREATER;
        end
        else
        begin
            status.cmp_end = ORD_LESS;
        end
        status.byte_lt   = (mem_q_reg < pat_k);
        status.byte_gt   = (mem_q_reg > pat_k);
        status.sfx_short = (fill_x < n_wide);
        status.sfx_done  = (k_reg == cnt_reg);
        status.dump_none = (n_now == '0);
        status.res_last  = res_last_reg;
    end

    // character store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.do_push)
        begin
            mem[wr_idx_reg] <= data_reg;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[pos_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_PATTERN_BYTES:  pat_bytes_reg <= cfg_data;
                    CFG_PATTERN_LENGTH: pat_len_reg   <= cfg_data[PLEN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.do_clear)
            begin
                rd_idx_reg <= '0;
                wr_idx_reg <= '0;
            end
            else
            begin
                if (cmd.do_push)
                begin
                    wr_idx_reg <= next_slot(wr_idx_reg);
                end
                if (cmd.do_pop)
                begin
                    rd_idx_reg <= next_slot(rd_idx_reg);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            kind_reg        <= kind_t'(s_tuser);
            data_reg        <= s_tdata[BYTE_W-1:0];
            len_reg         <= s_tdata[BYTE_W +: LEN_W];
            res_byte_reg    <= '0;
            res_valid_reg   <= 1'b0;
            res_order_reg   <= ORD_EQUAL;
            res_sfx_reg     <= 1'b0;
            res_refused_reg <= 1'b0;
            res_last_reg    <= 1'b1;
        end
        if (cmd.walk_head)
        begin
            pos_reg <= rd_idx_reg;
            k_reg   <= '0;
            cnt_reg <= n_now;
        end
        else if (cmd.walk_tail)
        begin
            pos_reg <= tail_pos;
            k_reg   <= '0;
            cnt_reg <= n_now;
        end
        else if (cmd.walk_step)
        begin
            pos_reg <= next_slot(pos_reg);
            k_reg   <= LEN_W'(k_reg + 1'b1);
        end
        if (cmd.set_refused)
        begin
            res_refused_reg <= 1'b1;
        end
        if (cmd.take_byte)
        begin
            res_byte_reg  <= mem_q_reg;
            res_valid_reg <= 1'b1;
            res_last_reg  <= (kind_reg != K_DUMP) || (LEN_W'(k_reg + 1'b1) == cnt_reg);
        end
        if (cmd.set_order)
        begin
            res_order_reg <= cmd.order_val;
        end
        if (cmd.set_sfx)
        begin
            res_sfx_reg <= cmd.sfx_val;
        end
        if (cmd.emit)
        begin
            out_byte_reg       <= res_byte_reg;
            out_byte_valid_reg <= res_valid_reg;
            out_fill_reg       <= fill_x[FILL_W-1:0];
            out_order_reg      <= res_order_reg;
            out_sfx_reg        <= res_sfx_reg;
            out_refused_reg    <= res_refused_reg;
            out_last_reg       <= res_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_refused_reg, out_sfx_reg, out_order_reg, out_fill_reg,
                       out_byte_valid_reg, out_byte_reg};

`ifndef SYNTHESIS
    a_refused_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_refused_reg) |-> !out_byte_valid_reg)
        else $error("refused beat carries a character");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_push |-> !status.full)
        else $error("push written into a full buffer");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pop |-> !status.empty)
        else $error("pop from an empty buffer");
`endif

endmodule

[hw/rtl/crbm_ctrl.sv]
module crbm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output crbm_pkg::cmd_t      cmd,
    input  crbm_pkg::status_t   status
);
    import crbm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_RD,
        S_POP_WAIT,
        S_CMP_TEST,
        S_CMP_CHK,
        S_SFX_TEST,
        S_SFX_CHK,
        S_DUMP_RD,
        S_DUMP_TAKE,
        S_DUMP_EMIT,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.kind)
                    K_PUSH:
                    begin
                        if (status.full)
                        begin
                            cmd.set_refused = 1'b1;
                        end
                        else
                        begin
                            cmd.do_push = 1'b1;
                        end
                        state_next = S_EMIT;
                    end
                    K_POP, K_PEEK:
                    begin
                        if (status.empty)
                        begin
                            cmd.set_refused = 1'b1;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            cmd.walk_head = 1'b1;
                            state_next    = S_POP_RD;
                        end
                    end
                    K_CLEAR:
                    begin
                        cmd.do_clear = 1'b1;
                        state_next   = S_EMIT;
                    end
                    K_COMPARE, K_LIMITED:
                    begin
                        cmd.walk_head = 1'b1;
                        state_next    = S_CMP_TEST;
                    end
                    K_ENDS:
                    begin
                        if (status.sfx_short)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.walk_tail = 1'b1;
                            state_next    = S_SFX_TEST;
                        end
                    end
                    K_DUMP:
                    begin
                        if (status.dump_none)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.walk_head = 1'b1;
                            state_next    = S_DUMP_RD;
                        end
                    end
                    default: state_next = S_EMIT;
                endcase
            end
            S_POP_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_POP_WAIT;
            end
            S_POP_WAIT:
            begin
                cmd.take_byte = 1'b1;
                cmd.do_pop    = (status.kind == K_POP);
                state_next    = S_EMIT;
            end
            S_CMP_TEST:
            begin
                if (status.cmp_more)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_CMP_CHK;
                end
                else
                begin
                    cmd.set_order = 1'b1;
                    cmd.order_val = status.cmp_end;
                    state_next    = S_EMIT;
                end
            end
            S_CMP_CHK:
            begin
                if (status.byte_lt)
                begin
                    cmd.set_order = 1'b1;
                    cmd.order_val = ORD_LESS;
                    state_next    = S_EMIT;
                end
                else if (status.byte_gt)
                begin
                    cmd.set_order = 1'b1;
                    cmd.order_val = ORD_GREATER;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_CMP_TEST;
                end
            end
            S_SFX_TEST:
            begin
                if (status.sfx_done)
                begin
                    cmd.set_sfx = 1'b1;
                    cmd.sfx_val = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SFX_CHK;
                end
            end
            S_SFX_CHK:
            begin
                if (status.byte_lt || status.byte_gt)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_SFX_TEST;
                end
            end
            S_DUMP_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_DUMP_TAKE;
            end
            S_DUMP_TAKE:
            begin
                cmd.take_byte = 1'b1;
                state_next    = S_DUMP_EMIT;
            end
            S_DUMP_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.res_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.walk_step = 1'b1;
                        state_next    = S_DUMP_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded over an untaken beat");

    a_decode_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE) |-> $past(state_reg == S_IDLE))
        else $error("decode entered without an accepted item");

    a_take_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_byte |-> $past(cmd.rd_en))
        else $error("store data used without a read the cycle before");
`endif

endmodule

[hw/rtl/char_ring_buffer_matcher.sv]
// sequence after accept: push, clear, refused pop/peek, an empty dump and a too-short
//   ends-with go from decode straight to emit; pop or peek reads the store and takes the
//   byte; compare or ends-with reads and checks one byte per step (at most 8 walked); dump
//   reads, takes and emits each byte in turn; every emit waits while the output stalls
// throughput: one item at a time; the next item is taken once the last beat of the
//   previous one is loaded into the output register
module char_ring_buffer_matcher #(
    parameter int DEPTH = 64    // store entries, holds DEPTH-1 characters
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // command stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [crbm_pkg::IN_TDATA_W-1:0]    s_tdata,   // data_byte[7:0], length[14:8], pad
    input  logic [crbm_pkg::KIND_W-1:0]        s_tuser,   // kind[2:0]

    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_byte[7:0], byte_valid[8], fill_count[14:9], order[16:15],
    // suffix_match[17], refused[18], pad
    output logic [crbm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast,   // last beat of an item's run

    // register writes: 0 pattern_bytes, 1 pattern_length
    input  logic                               cfg_we,
    input  logic [crbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crbm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import crbm_pkg::*;

    // reset: rst_n asynchronous active low; empties the buffer, clears both pattern registers

    // controller sequences each command; datapath owns the store, indices,
    // pattern registers, walk counters and the output register
    cmd_t    cmd;
    status_t status;

    crbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // the output register lets a new command be taken while the last beat waits
    crbm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

[bench/tb_char_ring_buffer_matcher.sv]
`timescale 1ns / 100ps

import crbm_pkg::*;

// one result beat as it appears on the master side
typedef struct packed {
    logic [7:0] ch;
    logic       ch_ok;
    logic [5:0] fill;
    order_t     ord;
    logic       sfx;
    logic       refused;
    logic       last;
} ring_beat_t;

// mirror of the ring contents and pattern registers, with the beats still owed
class ring_mirror;
    int           slots;
    logic [7:0]   chars [];
    int           rd;
    int           wr;
    logic [63:0]  pat;
    logic [3:0]   plen;
    ring_beat_t   owed [$];
    int           errors;

    function new(int n);
        slots  = n;
        chars  = new[n];
        rd     = 0;
        wr     = 0;
        pat    = '0;
        plen   = '0;
        errors = 0;
    endfunction

    function int held();
        return (wr + slots - rd) % slots;
    endfunction

    function logic [7:0] pat_at(int i);
        return pat[(i % 8) * 8 +: 8];
    endfunction

    // length register clamped to eight, cut at the first zero byte
    function int pat_used();
        int n;
        n = (plen > PATTERN_MAX) ? PATTERN_MAX : int'(plen);
        for (int i = 0; i < n; i++)
            if (pat_at(i) == 8'h00)
                return i;
        return n;
    endfunction

    function int pending();
        return owed.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [63:0] v);
        case (idx)
            CFG_PATTERN_BYTES:  pat  = v;
            CFG_PATTERN_LENGTH: plen = v[3:0];
            default: ;
        endcase
    endfunction

    // lim < 0: no limit
    function order_t order_against(int lim);
        int used;
        int fill;
        int pos;
        int k;
        used = pat_used();
        fill = held();
        pos  = rd;
        k    = 0;
        while (k < fill && k < used && (lim < 0 || k != lim)) begin
            if (chars[pos] < pat_at(k))
                return ORD_LESS;
            if (chars[pos] > pat_at(k))
                return ORD_GREATER;
            pos = (pos + 1) % slots;
            k++;
        end
        if (lim >= 0 && k == lim)
            return ORD_EQUAL;
        if (k == fill && k == used)
            return ORD_EQUAL;
        if (k == used)
            return ORD_GREATER;
        return ORD_LESS;
    endfunction

    function bit tail_matches(int n);
        int used;
        int fill;
        int pos;
        used = pat_used();
        fill = held();
        if (n > used)
            n = used;
        if (fill < n)
            return 1'b0;
        pos = (wr + slots - n) % slots;
        for (int j = 0; j < n; j++) begin
            if (chars[pos] !== pat_at(j))
                return 1'b0;
            pos = (pos + 1) % slots;
        end
        return 1'b1;
    endfunction

    function void owe_beat(logic [7:0] ch, logic ch_ok, order_t ord, logic sfx,
                           logic refused, logic last);
        ring_beat_t b;
        b.ch      = ch;
        b.ch_ok   = ch_ok;
        b.fill    = 6'(held());
        b.ord     = ord;
        b.sfx     = sfx;
        b.refused = refused;
        b.last    = last;
        owed.push_back(b);
    endfunction

    function void take_command(kind_t k, logic [7:0] d, logic [6:0] l);
        int fill;
        int n;
        int pos;
        fill = held();
        case (k)
            K_PUSH:
                if (fill >= slots - 1)
                    owe_beat(8'h00, 1'b0, ORD_EQUAL, 1'b0, 1'b1, 1'b1);
                else begin
                    chars[wr] = d;
                    wr = (wr + 1) % slots;
                    owe_beat(8'h00, 1'b0, ORD_EQUAL, 1'b0, 1'b0, 1'b1);
                end
            K_POP, K_PEEK:
                if (fill == 0)
                    owe_beat(8'h00, 1'b0, ORD_EQUAL, 1'b0, 1'b1, 1'b1);
                else begin
                    pos = rd;
                    if (k == K_POP)
                        rd = (rd + 1) % slots;
                    owe_beat(chars[pos], 1'b1, ORD_EQUAL, 1'b0, 1'b0, 1'b1);
                end
            K_CLEAR:
            begin
                rd = 0;
                wr = 0;
                owe_beat(8'h00, 1'b0, ORD_EQUAL, 1'b0, 1'b0, 1'b1);
            end
            K_COMPARE:
                owe_beat(8'h00, 1'b0, order_against(-1), 1'b0, 1'b0, 1'b1);
            K_LIMITED:
                owe_beat(8'h00, 1'b0, order_against(int'(l)), 1'b0, 1'b0, 1'b1);
            K_ENDS:
                owe_beat(8'h00, 1'b0, ORD_EQUAL, tail_matches(int'(l)), 1'b0, 1'b1);
            default:
            begin
                n = (int'(l) < fill) ? int'(l) : fill;
                if (n == 0)
                    owe_beat(8'h00, 1'b0, ORD_EQUAL, 1'b0, 1'b0, 1'b1);
                pos = rd;
                for (int j = 0; j < n; j++) begin
                    owe_beat(chars[pos], 1'b1, ORD_EQUAL, 1'b0, 1'b0, j == n - 1);
                    pos = (pos + 1) % slots;
                end
            end
        endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // fields widened with zeros so the signed order compares as raw bits
    function void match_beat(logic [OUT_TDATA_W-1:0] td, logic tl);
        ring_beat_t want;
        if (owed.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got data %h last %b",
                     $time, td, tl);
            errors++;
            return;
        end
        want = owed.pop_front();
        compare_field("out_byte", want.ch, td[7:0]);
        compare_field("byte_valid", {7'd0, want.ch_ok}, {7'd0, td[8]});
        compare_field("fill_count", {2'd0, want.fill}, {2'd0, td[14:9]});
        compare_field("order", {6'd0, want.ord}, {6'd0, td[16:15]});
        compare_field("suffix_match", {7'd0, want.sfx}, {7'd0, td[17]});
        compare_field("refused", {7'd0, want.refused}, {7'd0, td[18]});
        compare_field("last", {7'd0, want.last}, {7'd0, tl});
    endfunction
endclass

module tb_char_ring_buffer_matcher;

    localparam int RING_SLOTS   = 64;
    localparam int CYCLE_LIMIT  = 800000;
    // quiet cycles after the last beat before touching registers or ending
    localparam int SETTLE_LEN   = 12;
    // directed pattern, first character in the low byte
    localparam logic [63:0] PAT_MIXED = 64'hFE7F_4342_41FF_0180;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_TDATA_W-1:0]    s_tdata;    // data_byte[7:0], length[14:8], pad
    logic [KIND_W-1:0]        s_tuser;    // kind[2:0]
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_tdata;    // out_byte, byte_valid, fill, order, sfx, refused
    logic                     m_tlast;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    ring_mirror  mirror;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          tx_calm = 1'b0;   // sender runs without gaps while set
    bit          rx_calm = 1'b0;   // receiver never stalls while set
    int          rx_wait = 0;

    char_ring_buffer_matcher #(
        .DEPTH     (RING_SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: check every accepted beat, then maybe stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                mirror.match_beat(m_tdata, m_tlast);
                rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 31) == 0)
                    rx_calm = !rx_calm;
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // one command beat; valid stays up into the next call when there is no gap
    task automatic send_item(kind_t k, logic [7:0] d, logic [6:0] l);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 19) == 0)
            tx_calm = !tx_calm;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, l, d};
        s_tuser  <= k;
        do
            @(posedge clk);
        while (!s_tready);
        mirror.take_command(k, d, l);
        items_sent++;
    endtask

    // wait for every owed beat, then let the block go quiet
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_LEN) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        mirror.write_reg(idx, v);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_pattern(logic [63:0] p, logic [3:0] n);
        write_reg(CFG_PATTERN_BYTES, p);
        write_reg(CFG_PATTERN_LENGTH, {60'd0, n});
    endtask

    // nonzero characters, sometimes with a zero byte that cuts the pattern short
    function automatic logic [63:0] random_pattern();
        logic [63:0] p;
        int          cut;
        for (int i = 0; i < 8; i++)
            p[i * 8 +: 8] = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 2) == 0)
        begin
            cut = $urandom_range(0, 7);
            p[cut * 8 +: 8] = 8'h00;
        end
        return p;
    endfunction

    // half the time a pattern character, so compares get past the first byte
    function automatic logic [7:0] any_byte();
        if ($urandom_range(0, 1) == 0)
            return mirror.pat_at($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    // often short lengths, with the range up to 64 and that top value mixed in
    function automatic logic [6:0] any_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 7'($urandom_range(0, 9));
        if (r < 9)
            return 7'($urandom_range(0, 64));
        return 7'd64;
    endfunction

    task automatic random_item(int push_pct);
        kind_t k;
        if ($urandom_range(0, 99) < push_pct)
            k = K_PUSH;
        else
        begin
            k = kind_t'($urandom_range(1, 7));
            // clears are kept rare so the ring gets deep
            if (k == K_CLEAR && $urandom_range(0, 3) != 0)
                k = K_PEEK;
        end
        send_item(k, any_byte(), any_length());
    endtask

    // clear, spell a pattern prefix, query it; then, half the time, a tail built for ends-with
    task automatic spell_pattern();
        int    n;
        int    m;
        int    junk;
        kind_t q;
        n = $urandom_range(0, 9);
        send_item(K_CLEAR, 8'($urandom_range(0, 255)), any_length());
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1 && $urandom_range(0, 4) == 0)
                send_item(K_PUSH, 8'($urandom_range(0, 255)), any_length());
            else
                send_item(K_PUSH, mirror.pat_at(i), any_length());
        end
        repeat ($urandom_range(1, 3))
        begin
            q = kind_t'($urandom_range(K_COMPARE, K_ENDS));
            send_item(q, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 1) == 0)
        begin
            m    = $urandom_range(0, 8);
            junk = $urandom_range(0, 2);
            repeat (junk)
                send_item(K_PUSH, 8'($urandom_range(0, 255)), any_length());
            for (int i = 0; i < m; i++)
                send_item(K_PUSH, mirror.pat_at(i), any_length());
            send_item(K_ENDS, 8'($urandom_range(0, 255)),
                      ($urandom_range(0, 2) == 0) ? any_length() : 7'(m));
        end
    endtask

    task automatic run_phase(int n_items, int push_pct, int spell_pct);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < spell_pct)
                spell_pattern();
            else
                random_item(push_pct);
        end
    endtask

    initial
    begin
        mirror = new(RING_SLOTS);
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= K_PUSH;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_PATTERN_BYTES;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: empty pattern
        send_item(K_POP, 8'h00, 7'd0);           // refused, empty
        send_item(K_COMPARE, 8'h00, 7'd0);       // empty against empty pattern: equal
        send_item(K_ENDS, 8'h00, 7'd5);          // length clamped to zero: match
        drain_results();

        load_pattern(PAT_MIXED, 4'd8);
        send_item(K_PEEK, 8'h00, 7'd0);          // refused, empty
        send_item(K_DUMP, 8'h00, 7'd5);          // nothing held: one bare beat
        send_item(K_COMPARE, 8'h00, 7'd0);       // buffer ends first: less
        send_item(K_LIMITED, 8'h00, 7'd0);       // zero limit: equal
        send_item(K_PUSH, 8'h80, 7'd0);
        send_item(K_PUSH, 8'h01, 7'd0);
        send_item(K_PUSH, 8'hFF, 7'd0);
        send_item(K_COMPARE, 8'h00, 7'd0);       // prefix only: less
        send_item(K_LIMITED, 8'h00, 7'd3);       // equal up to the limit
        send_item(K_ENDS, 8'h00, 7'd2);          // tail differs from pattern head
        send_item(K_ENDS, 8'h00, 7'd3);          // whole buffer is the pattern head
        send_item(K_ENDS, 8'h00, 7'd64);         // clamped to eight, too few held
        send_item(K_PUSH, 8'hFF, 7'd0);
        send_item(K_COMPARE, 8'h00, 7'd0);       // fourth byte above pattern: greater
        send_item(K_PUSH, 8'h00, 7'd0);
        send_item(K_PEEK, 8'h00, 7'd0);
        send_item(K_DUMP, 8'h00, 7'd64);         // count capped by fill
        send_item(K_POP, 8'h00, 7'd0);
        send_item(K_COMPARE, 8'h00, 7'd0);       // now starts below pattern: less
        send_item(K_CLEAR, 8'h00, 7'd0);
        send_item(K_COMPARE, 8'h00, 7'd0);
        drain_results();

        // push-heavy run that fills the ring and hits refused pushes
        load_pattern(random_pattern(), 4'd8);
        run_phase(85, 95, 0);
        drain_results();

        // mixed traffic with spelled patterns, random length
        load_pattern(random_pattern(), 4'($urandom_range(0, 8)));
        run_phase(30, 40, 30);
        drain_results();

        // top character values everywhere
        load_pattern(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        run_phase(12, 40, 40);
        drain_results();

        // real characters but zero length
        load_pattern(random_pattern(), 4'd0);
        run_phase(8, 40, 20);
        drain_results();

        // run with few pushes, to let the ring drain
        load_pattern(random_pattern(), 4'($urandom_range(1, 8)));
        run_phase(15, 20, 20);
        drain_results();

        if (mirror.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/crbm_pkg.sv
hw/rtl/crbm_dp.sv
hw/rtl/crbm_ctrl.sv
hw/rtl/char_ring_buffer_matcher.sv
bench/tb_char_ring_buffer_matcher.sv
